// File: rtl/spms_pkg.sv
// Shared constants, result type and saturation helper for the sign-pattern search.
package spms_pkg;

  localparam int DEF_MAX_STATES   = 8;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int ACC_W      = 48;
  localparam int CLAMP_IN_W = 96;
  localparam int NS_W       = 4;
  localparam int WEIGHT_W   = 16;
  localparam int IDX_W      = 7;
  localparam int CHANGE_W   = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 1'b1;

  localparam logic [NS_W-1:0]     RESET_NUM_STATES = 4'd2;
  localparam logic [WEIGHT_W-1:0] RESET_WEIGHT     = 16'd256;

  typedef struct packed {
    logic                       found;
    logic [IDX_W-1:0]           pattern_index;
    logic [IDX_W-1:0]           flip_mask;
    logic signed [CHANGE_W-1:0] best_change;
  } search_result_t;

  // Clamp a wide signed value to the signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [CLAMP_IN_W-1:0] x);
    logic [CLAMP_IN_W-ACC_W:0] upper;
    logic signed [ACC_W-1:0]   res;
    upper = x[CLAMP_IN_W-1:ACC_W-1];
    if ((&upper) || !(|upper)) begin
      res = x[ACC_W-1:0];
    end else if (x[CLAMP_IN_W-1]) begin
      res = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: rtl/spms_term.sv
// Saturating weighted term unit: one shared multiplier stepped by a small sequencer.
module spms_term #(
  parameter int SAMPLE_WIDTH = spms_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [spms_pkg::WEIGHT_W-1:0]      weight,
  input  logic signed [SAMPLE_WIDTH-1:0]     value_a,
  input  logic signed [SAMPLE_WIDTH-1:0]     ref_a,
  input  logic signed [SAMPLE_WIDTH-1:0]     value_b,
  input  logic signed [SAMPLE_WIDTH-1:0]     ref_b,
  output logic                               done,
  output logic signed [spms_pkg::ACC_W-1:0]  term
);

  localparam int PA_W = (2 * SAMPLE_WIDTH < spms_pkg::ACC_W) ? 2 * SAMPLE_WIDTH
                                                             : spms_pkg::ACC_W;
  localparam int MB_W = (SAMPLE_WIDTH > spms_pkg::WEIGHT_W) ? SAMPLE_WIDTH
                                                            : spms_pkg::WEIGHT_W + 1;
  localparam int P_W  = PA_W + MB_W;

  typedef enum logic [2:0] {T_IDLE, T_MUL_A, T_MUL_B, T_MUL_W, T_SUM} tstate_t;

  tstate_t                            state;
  logic signed [SAMPLE_WIDTH-1:0]     va, ra, vb, rb;
  logic [spms_pkg::WEIGHT_W-1:0]      wgt;
  logic signed [PA_W-1:0]             pa, pb;
  logic signed [spms_pkg::ACC_W-1:0]  ta, tb;
  logic signed [PA_W-1:0]             mul_a;
  logic signed [MB_W-1:0]             mul_b;
  logic signed [P_W-1:0]              prod;
  logic signed [spms_pkg::CLAMP_IN_W-1:0] prod_wide, pb_shift;

  // Operand select for the shared multiplier.
  always_comb begin
    case (state)
      T_MUL_B: begin
        mul_a = PA_W'(vb);
        mul_b = MB_W'(rb);
      end
      T_MUL_W: begin
        mul_a = pa;
        mul_b = MB_W'(signed'({1'b0, wgt}));
      end
      default: begin
        mul_a = PA_W'(va);
        mul_b = MB_W'(ra);
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign prod_wide = spms_pkg::CLAMP_IN_W'(prod);
  assign pb_shift  = spms_pkg::CLAMP_IN_W'(pb) <<< 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      // Pulse done for one cycle once the final add is registered.
      done <= (state == T_SUM);
      case (state)
        T_IDLE: begin
          if (start) begin
            va    <= value_a;
            ra    <= ref_a;
            vb    <= value_b;
            rb    <= ref_b;
            wgt   <= weight;
            state <= T_MUL_A;
          end
        end
        T_MUL_A: begin
          pa    <= PA_W'(spms_pkg::sat_acc(prod_wide));
          state <= T_MUL_B;
        end
        T_MUL_B: begin
          pb    <= PA_W'(spms_pkg::sat_acc(prod_wide));
          state <= T_MUL_W;
        end
        T_MUL_W: begin
          ta    <= spms_pkg::sat_acc(prod_wide);
          tb    <= spms_pkg::sat_acc(pb_shift);
          state <= T_SUM;
        end
        T_SUM: begin
          term  <= spms_pkg::sat_acc(spms_pkg::CLAMP_IN_W'(ta) + spms_pkg::CLAMP_IN_W'(tb));
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/spms_search.sv
// Pattern walker: one pair read per cycle, shared cost adder and best-cost compare.
module spms_search #(
  parameter int MAX_STATES = spms_pkg::DEF_MAX_STATES
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [spms_pkg::NS_W-1:0]                 n,
  output logic                                      rd_en,
  output logic [$clog2(MAX_STATES*MAX_STATES)-1:0]  rd_addr,
  input  logic signed [spms_pkg::ACC_W-1:0]         rd_data,
  output logic                                      done,
  output spms_pkg::search_result_t                  result
);

  localparam int ML     = MAX_STATES - 1;
  localparam int IW     = $clog2(MAX_STATES);
  localparam int AW     = $clog2(MAX_STATES * MAX_STATES);
  localparam int SUM_W  = spms_pkg::ACC_W + AW;
  localparam int COST_W = SUM_W + 2;

  typedef enum logic {S_IDLE, S_RUN} sstate_t;

  sstate_t                    state;
  logic [ML-1:0]              mask, max_mask, p1_mask, p2_mask, best_mask;
  logic [spms_pkg::NS_W-1:0]  n_m1;
  logic [IW-1:0]              i, j;
  logic                       p1_valid, p1_diff, p1_end, p1_last;
  logic                       p2_valid, p2_last;
  logic signed [SUM_W-1:0]    cost, fin_cost;
  logic signed [COST_W-1:0]   best;
  logic                       found;

  logic [MAX_STATES-1:0]      mask_ext;
  logic                       row_end, pat_end, final_issue;
  logic signed [SUM_W-1:0]    addend;
  logic signed [COST_W-1:0]   cost4;

  // States at or above n-1 are positive; mask bits there are zero already.
  assign mask_ext    = {1'b0, mask};
  assign row_end     = (spms_pkg::NS_W'(j) == n_m1);
  assign pat_end     = row_end && (spms_pkg::NS_W'(i) == n_m1 - 1'b1);
  assign final_issue = pat_end && (mask == max_mask);
  assign rd_en       = (state == S_RUN);
  assign rd_addr     = AW'(i * MAX_STATES + j);
  assign addend      = p1_diff ? SUM_W'(rd_data) : '0;
  assign cost4       = signed'({fin_cost, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      done     <= 1'b0;
      found    <= 1'b0;
    end else begin
      // Finish at once with fewer than two states, else after the last compare.
      done     <= ((state == S_IDLE) && start && (n < spms_pkg::NS_W'(2))) ||
                  (p2_valid && p2_last);
      p1_valid <= (state == S_RUN);
      p2_valid <= p1_valid && p1_end;

      case (state)
        S_IDLE: begin
          if (start) begin
            best      <= '0;
            found     <= 1'b0;
            best_mask <= '0;
            cost      <= '0;
            if (n >= spms_pkg::NS_W'(2)) begin
              n_m1     <= n - 1'b1;
              max_mask <= ~({ML{1'b1}} << (n - 1'b1));
              mask     <= ML'(1);
              i        <= '0;
              j        <= IW'(1);
              state    <= S_RUN;
            end
          end
        end
        S_RUN: begin
          p1_diff  <= mask_ext[i] ^ mask_ext[j];
          p1_end   <= pat_end;
          p1_last  <= final_issue;
          p1_mask  <= mask;
          if (pat_end) begin
            i    <= '0;
            j    <= IW'(1);
            mask <= mask + 1'b1;
          end else if (row_end) begin
            i <= i + 1'b1;
            j <= IW'(i + 2);
          end else begin
            j <= j + 1'b1;
          end
          if (final_issue) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Sum the pairs of one pattern; hand the total to the compare stage.
      if (p1_valid) begin
        if (p1_end) begin
          fin_cost <= cost + addend;
          cost     <= '0;
          p2_last  <= p1_last;
          p2_mask  <= p1_mask;
        end else begin
          cost <= cost + addend;
        end
      end

      // Keep the first strictly lowest cost below zero.
      if (p2_valid) begin
        if (cost4 < best) begin
          best      <= cost4;
          found     <= 1'b1;
          best_mask <= p2_mask;
        end
      end
    end
  end

  always_comb begin
    result.found         = found;
    result.pattern_index = found ? spms_pkg::IDX_W'(best_mask - 1'b1) : '0;
    result.flip_mask     = found ? spms_pkg::IDX_W'(best_mask) : '0;
    result.best_change   = spms_pkg::CHANGE_W'(best);
  end

endmodule

// File: rtl/sign_pattern_min_search.sv
// Top level of the sign-pattern search: pair-sum memory, control sequencer and result register.
//
// Each input transaction carries one upper off-diagonal element (row < col < num_states)
// of two observables and their references; the block adds the saturated term
// weight*value_a*ref_a + 256*value_b*ref_b (units of 2^-38) into a 48-bit saturating
// accumulator for that pair. An element that is accumulated occupies the block while
// the term unit runs three multiplies and one add on its single shared multiplier,
// then the pair memory is updated by read-modify-write. An element outside the upper
// triangle is not accumulated. On a transaction with last set, the block walks every
// sign mask 1 .. 2^(n-1)-1 (last state positive) and reads one pair sum per cycle from
// the memory's single read port, with n = min(num_states, MAX_STATES). One result
// transaction follows: the first pattern whose cost 4*sum(differing pairs) is below zero
// and below every earlier one, or found = 0 with zero fields. Accumulators are cleared
// at reset and after each result by per-entry valid bits, so no clearing pass is needed.
// in_stall stays high while an element or a search is in progress, and while a result
// waits for the output register. The user must write num_states and weight on the cfg
// channel only while idle; the block itself does not enforce this.
module sign_pattern_min_search #(
  parameter int MAX_STATES   = spms_pkg::DEF_MAX_STATES,
  parameter int SAMPLE_WIDTH = spms_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spms_pkg::WEIGHT_W-1:0]        cfg_data,
  // element input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           row,
  input  logic [2:0]                           col,
  input  logic signed [SAMPLE_WIDTH-1:0]       value_a,
  input  logic signed [SAMPLE_WIDTH-1:0]       ref_a,
  input  logic signed [SAMPLE_WIDTH-1:0]       value_b,
  input  logic signed [SAMPLE_WIDTH-1:0]       ref_b,
  input  logic                                 last,
  // search result
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [spms_pkg::IDX_W-1:0]           pattern_index,
  output logic [spms_pkg::IDX_W-1:0]           flip_mask,
  output logic signed [spms_pkg::CHANGE_W-1:0] best_change
);

  localparam int NPAIRS = MAX_STATES * MAX_STATES;
  localparam int AW     = $clog2(NPAIRS);

  typedef enum logic [1:0] {ST_IDLE, ST_TERM, ST_SEARCH, ST_RESULT} state_t;

  state_t                             state;
  logic [spms_pkg::NS_W-1:0]          num_states;
  logic [spms_pkg::WEIGHT_W-1:0]      weight;
  logic [AW-1:0]                      addr_q;
  logic                               last_q;

  // pair-sum memory with per-entry valid bits
  logic signed [spms_pkg::ACC_W-1:0]  mem [NPAIRS];
  logic [NPAIRS-1:0]                  entry_valid;
  logic signed [spms_pkg::ACC_W-1:0]  rd_q;
  logic                               vld_q;
  logic signed [spms_pkg::ACC_W-1:0]  rd_eff;

  logic [spms_pkg::NS_W-1:0]          n_eff;
  logic                               in_acc, acc_ok, out_free;
  logic [AW-1:0]                      in_addr, rd_addr;
  logic                               rd_en, wr_en;
  logic signed [spms_pkg::ACC_W-1:0]  wr_data;

  logic                               term_start, term_done;
  logic signed [spms_pkg::ACC_W-1:0]  term;

  logic                               srch_start, srch_done, srch_rd_en;
  logic [AW-1:0]                      srch_addr;
  spms_pkg::search_result_t           srch_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Clip the state count to what the memory holds.
  assign n_eff   = (num_states > spms_pkg::NS_W'(MAX_STATES)) ? spms_pkg::NS_W'(MAX_STATES)
                                                              : num_states;
  assign acc_ok  = (n_eff >= spms_pkg::NS_W'(2)) && (col > row) &&
                   (spms_pkg::NS_W'(col) < n_eff);
  assign in_addr = AW'(row * MAX_STATES + col);

  assign term_start = in_acc && acc_ok;
  assign srch_start = (in_acc && !acc_ok && last) ||
                      ((state == ST_TERM) && term_done && last_q);

  // The search owns the read port while it runs; otherwise read the incoming pair.
  assign rd_en   = term_start || srch_rd_en;
  assign rd_addr = srch_rd_en ? srch_addr : in_addr;
  assign rd_eff  = vld_q ? rd_q : '0;

  assign wr_en   = (state == ST_TERM) && term_done;
  assign wr_data = spms_pkg::sat_acc(spms_pkg::CLAMP_IN_W'(rd_eff) +
                                     spms_pkg::CLAMP_IN_W'(term));

  spms_term #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .start   (term_start),
    .weight  (weight),
    .value_a (value_a),
    .ref_a   (ref_a),
    .value_b (value_b),
    .ref_b   (ref_b),
    .done    (term_done),
    .term    (term)
  );

  spms_search #(
    .MAX_STATES (MAX_STATES)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .n       (n_eff),
    .rd_en   (srch_rd_en),
    .rd_addr (srch_addr),
    .rd_data (rd_eff),
    .done    (srch_done),
    .result  (srch_res)
  );

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      vld_q <= entry_valid[rd_addr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= spms_pkg::RESET_NUM_STATES;
      weight     <= spms_pkg::RESET_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spms_pkg::REG_NUM_STATES: num_states <= cfg_data[spms_pkg::NS_W-1:0];
        spms_pkg::REG_WEIGHT:     weight     <= cfg_data;
        default:                  ;
      endcase
    end
  end

  // Sequencer, valid bits and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      // drop a taken result; a waiting search result reloads the register below
      if (out_valid && !out_stall && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[addr_q] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            addr_q <= in_addr;
            last_q <= last;
            if (acc_ok) begin
              state <= ST_TERM;
            end else if (last) begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_TERM: begin
          // write back the updated pair, then search or go idle
          if (term_done) begin
            state <= last_q ? ST_SEARCH : ST_IDLE;
          end
        end
        ST_SEARCH: begin
          if (srch_done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          // hold the search result until the output register frees up
          if (out_free) begin
            out_valid     <= 1'b1;
            found         <= srch_res.found;
            pattern_index <= srch_res.pattern_index;
            flip_mask     <= srch_res.flip_mask;
            best_change   <= srch_res.best_change;
            entry_valid   <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> pattern_index == '0 && flip_mask == '0 && best_change == '0)
    else $error("result without a pattern carries nonzero fields");

  a_found_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> best_change[spms_pkg::CHANGE_W-1] &&
                           flip_mask == pattern_index + 7'd1)
    else $error("found pattern has a non-negative cost or a mismatched mask");

  a_term_in_term: assert property (@(posedge clk) disable iff (rst)
    term_done |-> state == ST_TERM)
    else $error("term unit finished outside an accumulate step");

  a_search_in_search: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> state == ST_SEARCH)
    else $error("search finished outside a search");

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !srch_rd_en)
    else $error("pair memory written while the search walks it");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sign-pattern minimum search block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_ST          = spms_pkg::DEF_MAX_STATES;
  localparam int     SW              = spms_pkg::DEF_SAMPLE_WIDTH;
  localparam int     ACC_W           = spms_pkg::ACC_W;
  localparam int     IDX_W           = spms_pkg::IDX_W;
  localparam int     NS_W            = spms_pkg::NS_W;
  localparam int     WEIGHT_W        = spms_pkg::WEIGHT_W;
  localparam int     CFG_IDX_W       = spms_pkg::CFG_IDX_W;
  localparam int     CHANGE_W        = spms_pkg::CHANGE_W;
  localparam longint ACC_HI          = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO          = -ACC_HI - 1;
  localparam int     TARGET_ELEMENTS = 1450;
  // Settle time before a register write: an accumulated element keeps the block
  // busy after its transaction while the term unit runs.
  localparam int     SETTLE_CYCLES   = 12;
  // Longer than a full eight-state search, so a result is sure to wait behind it.
  localparam int     LONG_HOLD       = 4000;
  // The longest quiet stretch is the long hold; allow several times that.
  localparam int     WATCHDOG_LIMIT  = 20000;
  localparam int     MAX_REPORTS     = 10;

  typedef struct {
    logic [2:0]           row;
    logic [2:0]           col;
    logic signed [SW-1:0] value_a;
    logic signed [SW-1:0] ref_a;
    logic signed [SW-1:0] value_b;
    logic signed [SW-1:0] ref_b;
    logic                 last;
  } element_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = spms_pkg::REG_NUM_STATES;
  logic [WEIGHT_W-1:0]   cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            row      = '0;
  logic [2:0]            col      = '0;
  logic signed [SW-1:0]  value_a  = '0;
  logic signed [SW-1:0]  ref_a    = '0;
  logic signed [SW-1:0]  value_b  = '0;
  logic signed [SW-1:0]  ref_b    = '0;
  logic                  last     = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  found;
  logic [IDX_W-1:0]      pattern_index;
  logic [IDX_W-1:0]      flip_mask;
  logic signed [CHANGE_W-1:0] best_change;

  // Elements waiting to be offered; the front one is on the bus while in_valid is high.
  element_t                 element_queue[$];
  // Search results predicted from accepted elements, oldest first.
  spms_pkg::search_result_t expected_results[$];

  // Shadow of the block's registers and pair accumulators.
  logic [NS_W-1:0]          shadow_states  = spms_pkg::RESET_NUM_STATES;
  logic [WEIGHT_W-1:0]      shadow_weight  = spms_pkg::RESET_WEIGHT;
  logic signed [ACC_W-1:0]  pair_acc [MAX_ST*MAX_ST] = '{default: '0};

  int   mismatches      = 0;
  int   idle_pct        = 0;
  int   elements_queued = 0;
  int   gap_left        = 0;
  int   stall_left      = 0;
  int   quiet_cycles    = 0;
  logic long_hold_req   = 1'b0;
  logic long_hold_taken = 1'b0;

  sign_pattern_min_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .row           (row),
    .col           (col),
    .value_a       (value_a),
    .ref_a         (ref_a),
    .value_b       (value_b),
    .ref_b         (ref_b),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .pattern_index (pattern_index),
    .flip_mask     (flip_mask),
    .best_change   (best_change)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_acc(input longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  // Fold one element into its pair sum; on the final element of a data set,
  // run the sign-mask search, fill in the result and clear all sums.
  function automatic bit accumulate_and_search(input element_t e,
                                               output spms_pkg::search_result_t res);
    int     n;
    int     k;
    int     p;
    int     i;
    int     j;
    int     mask;
    int     best_p;
    bit     hit;
    bit     si;
    bit     sj;
    longint prod_a;
    longint prod_b;
    longint term;
    longint cost;
    longint best;
    n = int'(shadow_states);
    if (n > MAX_ST) n = MAX_ST;
    res = '0;
    // Only the upper triangle inside the active size is accumulated.
    if (n >= 2 && e.col > e.row && int'(e.col) < n) begin
      prod_a = clamp_acc(longint'(e.value_a) * longint'(e.ref_a));
      prod_b = clamp_acc(longint'(e.value_b) * longint'(e.ref_b));
      term   = clamp_acc(clamp_acc(prod_a * longint'(shadow_weight)) +
                         clamp_acc(prod_b * 256));
      k      = int'(e.row) * MAX_ST + int'(e.col);
      pair_acc[k] = ACC_W'(clamp_acc(longint'(pair_acc[k]) + term));
    end
    if (!e.last) return 1'b0;
    best   = 0;
    best_p = 0;
    hit    = 1'b0;
    if (n >= 2) begin
      for (p = 0; p < (1 << (n - 1)) - 1; p++) begin
        mask = p + 1;
        cost = 0;
        for (i = 0; i + 1 < n; i++) begin
          for (j = i + 1; j < n; j++) begin
            si = mask[i];
            // The highest state never flips.
            sj = (j < n - 1) ? mask[j] : 1'b0;
            if (si ^ sj) cost += longint'(pair_acc[i * MAX_ST + j]);
          end
        end
        cost = cost * 4;
        // Strictly lower only: ties keep the earlier pattern.
        if (cost < best) begin
          best   = cost;
          best_p = p;
          hit    = 1'b1;
        end
      end
    end
    if (hit) begin
      res.found         = 1'b1;
      res.pattern_index = best_p[IDX_W-1:0];
      res.flip_mask     = IDX_W'(best_p + 1);
      res.best_change   = best;
    end
    foreach (pair_acc[m]) pair_acc[m] = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the front of element_queue; on each accepted transaction pop
  // it and record its prediction in the same step, so the queues never disagree.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : element_driver
    spms_pkg::search_result_t res;
    element_t                 done;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        done = element_queue.pop_front();
        if (accumulate_and_search(done, res)) expected_results.push_back(res);
      end
      // Free to change the bus only when nothing is held or the held item just left.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (element_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          // Idle burst: drop in_valid and start a random gap.
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b1;
          row      <= element_queue[0].row;
          col      <= element_queue[0].col;
          value_a  <= element_queue[0].value_a;
          ref_a    <= element_queue[0].ref_a;
          value_b  <= element_queue[0].value_b;
          ref_b    <= element_queue[0].ref_b;
          last     <= element_queue[0].last;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold_req && !long_hold_taken) begin
      out_stall       <= 1'b1;
      stall_left      <= LONG_HOLD - 1;
      long_hold_taken <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    spms_pkg::search_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with none expected: found=%0d idx=%0d mask=%0d change=%0d",
                   $realtime, found, pattern_index, flip_mask, best_change);
      end else begin
        want = expected_results.pop_front();
        if (found !== want.found || pattern_index !== want.pattern_index ||
            flip_mask !== want.flip_mask || best_change !== want.best_change) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] result mismatch: exp found=%0d idx=%0d mask=%0d change=%0d,",
                      " got found=%0d idx=%0d mask=%0d change=%0d"},
                     $realtime, want.found, want.pattern_index, want.flip_mask,
                     want.best_change, found, pattern_index, flip_mask, best_change);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sign_pattern_min_search");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the shadow copy. Then wait with cfg_valid low
  // so a following write never raises cfg_valid in the step that lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == spms_pkg::REG_NUM_STATES) shadow_states = data[NS_W-1:0];
    else shadow_weight = data;
    @(posedge clk);
  endtask

  task automatic push_element(input logic [2:0] r, input logic [2:0] c,
                              input logic signed [SW-1:0] va, input logic signed [SW-1:0] ra,
                              input logic signed [SW-1:0] vb, input logic signed [SW-1:0] rb,
                              input logic lst);
    element_t e;
    e.row     = r;
    e.col     = c;
    e.value_a = va;
    e.ref_a   = ra;
    e.value_b = vb;
    e.ref_b   = rb;
    e.last    = lst;
    element_queue.push_back(e);
    elements_queued++;
  endtask

  // Mix of full-range, full-scale and near-zero samples.
  function automatic logic signed [SW-1:0] rand_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if (sel < 3) return SW'(int'($urandom_range(0, 200)) - 100);
    return SW'($urandom);
  endfunction

  // One data set ending in a last element. Most elements hit a live pair; the
  // rest are random coordinates, mostly ignored. Some sets use matching signs
  // so that every pair sum is non-negative and no pattern can win.
  task automatic queue_data_set(input int eff_n, input int set_len);
    element_t e;
    int       k;
    bit       same_sign;
    same_sign = ($urandom_range(0, 4) == 0);
    for (k = 0; k < set_len; k++) begin
      if (eff_n >= 2 && $urandom_range(0, 9) < 8) begin
        e.row = 3'($urandom_range(0, eff_n - 2));
        e.col = 3'($urandom_range(int'(e.row) + 1, eff_n - 1));
      end else begin
        e.row = 3'($urandom);
        e.col = 3'($urandom);
      end
      e.value_a = rand_sample();
      e.ref_a   = rand_sample();
      e.value_b = rand_sample();
      e.ref_b   = rand_sample();
      if (same_sign) begin
        e.ref_a = e.value_a;
        e.ref_b = e.value_b;
      end
      e.last = (k == set_len - 1);
      element_queue.push_back(e);
      elements_queued++;
    end
  endtask

  // Hold the sender until every element has gone in and every result is out,
  // then let the block settle.
  task automatic wait_idle();
    while (element_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int               n_cfg;
    int               eff_n;
    int               sets;
    int               s;
    int               phase;
    int               big_left;
    int               sel;
    logic [WEIGHT_W-1:0] w;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- Directed part ------------------------------------------------------
    // Full-scale weight, four states: saturate one pair positive, another negative.
    write_reg(spms_pkg::REG_NUM_STATES, 16'd4);
    write_reg(spms_pkg::REG_WEIGHT, 16'hFFFF);
    idle_pct = 20;
    repeat (3) push_element(3'd0, 3'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    repeat (3) push_element(3'd1, 3'd2, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
    push_element(3'd2, 3'd3, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    // Elements below the diagonal, on it, or past the active size are dropped.
    push_element(3'd3, 3'd2, 16'sh1234, 16'sh4321, -16'sh0777, 16'sh0555, 1'b0);
    push_element(3'd7, 3'd7, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    push_element(3'd0, 3'd7, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
    // Last flag on a dropped element still starts the search.
    push_element(3'd2, 3'd2, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
    push_element(3'd0, 3'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
    // A set holding only a dropped element: all sums zero, nothing found.
    push_element(3'd7, 3'd0, -16'sh0001, 16'sh0001, 16'sh0001, -16'sh0001, 1'b1);
    wait_idle();

    // Zero weight: only the second observable counts.
    write_reg(spms_pkg::REG_NUM_STATES, 16'd2);
    write_reg(spms_pkg::REG_WEIGHT, 16'h0000);
    push_element(3'd0, 3'd1, 16'sh7FFF, 16'sh8000, 16'sh0001, -16'sh0001, 1'b1);
    wait_idle();

    // Fewer than two states: no patterns at all.
    write_reg(spms_pkg::REG_NUM_STATES, 16'd0);
    push_element(3'd0, 3'd1, -16'sh0005, 16'sh0007, 16'sh0003, -16'sh0002, 1'b1);
    wait_idle();
    write_reg(spms_pkg::REG_NUM_STATES, 16'd1);
    push_element(3'd0, 3'd1, -16'sh0005, 16'sh0007, 16'sh0003, -16'sh0002, 1'b1);
    wait_idle();

    // Oversized count clamps to the full eight states.
    write_reg(spms_pkg::REG_NUM_STATES, 16'hFFFF);
    write_reg(spms_pkg::REG_WEIGHT, spms_pkg::RESET_WEIGHT);
    push_element(3'd0, 3'd1, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 1'b0);
    push_element(3'd6, 3'd7, -16'sh4000, 16'sh4000, 16'sh2000, -16'sh2000, 1'b1);
    wait_idle();

    // --- Random part --------------------------------------------------------
    phase    = 0;
    big_left = 6;
    while (elements_queued < TARGET_ELEMENTS) begin
      phase++;
      // Mostly small sizes; a handful of large or out-of-range ones.
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        case ($urandom_range(0, 2))
          0: n_cfg = $urandom_range(0, 1);
          1: n_cfg = $urandom_range(9, 15);
          default: n_cfg = 2;
        endcase
      end else if (sel < 14 && big_left > 0) begin
        n_cfg = $urandom_range(6, 8);
      end else begin
        n_cfg = $urandom_range(2, 5);
      end
      eff_n = (n_cfg > MAX_ST) ? MAX_ST : n_cfg;
      if (eff_n >= 6) big_left--;

      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = '1;
        2:       w = spms_pkg::RESET_WEIGHT;
        default: w = WEIGHT_W'($urandom);
      endcase

      // Upper data bits of the size write are don't-care; randomize them.
      if ($urandom_range(0, 1)) begin
        write_reg(spms_pkg::REG_NUM_STATES, {12'($urandom), 4'(n_cfg)});
        write_reg(spms_pkg::REG_WEIGHT, w);
      end else begin
        write_reg(spms_pkg::REG_WEIGHT, w);
        write_reg(spms_pkg::REG_NUM_STATES, {12'($urandom), 4'(n_cfg)});
      end

      // Drop idling for the tail of the run; elsewhere vary it per phase.
      if (elements_queued > TARGET_ELEMENTS - 200) idle_pct = 0;
      else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end

      sets = (eff_n >= 6) ? $urandom_range(1, 2) : $urandom_range(2, 7);
      for (s = 0; s < sets; s++)
        queue_data_set(eff_n, ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10));

      // Once, hold the receiver off while the sender keeps offering: the output
      // register fills and the block must stall its input.
      if (phase == 4) begin
        for (s = 0; s < 4; s++) queue_data_set(eff_n, $urandom_range(2, 6));
        long_hold_req <= 1'b1;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS sign_pattern_min_search");
    end else begin
      $display("FAIL sign_pattern_min_search");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spms_pkg.sv
rtl/spms_term.sv
rtl/spms_search.sv
rtl/sign_pattern_min_search.sv
tb/tb_top.sv
